// ===== hdl/sete_pkg.sv =====
// Shared types and constants for the sprite entry tile expander.
// No dependencies; used by every module under hdl/.
package sete_pkg;

    // Default depth of the entry queue between front and back
    localparam int SETE_QUEUE_DEPTH = 4;

    // Attribute byte bit positions
    localparam int ATTR_VISIBLE = 7;
    localparam int ATTR_SIZE_HI = 5;
    localparam int ATTR_SIZE_LO = 4;
    localparam int ATTR_XFLIP   = 3;
    localparam int ATTR_YFLIP   = 2;
    localparam int ATTR_XHIGH   = 1;
    localparam int ATTR_YHIGH   = 0;

    // Screen origin for inverted coordinates
    localparam logic [9:0] SCREEN_ORIGIN = 10'd240;
    // Step between neighboring tiles of one sprite
    localparam logic [9:0] TILE_STEP     = 10'd16;

    // Size codes from attribute bits 5-4
    typedef enum logic [1:0] {
        SIZE_1X1 = 2'd0,
        SIZE_1X2 = 2'd1,
        SIZE_2X1 = 2'd2,
        SIZE_2X2 = 2'd3
    } t_size;

    // One decoded, visible sprite entry
    typedef struct packed {
        logic [12:0]       base_code;
        logic [2:0]        color;
        logic              flip_x;
        logic              flip_y;
        logic signed [9:0] pos_x;
        logic signed [9:0] pos_y;
        t_size             size;
    } t_entry;

endpackage

// ===== hdl/sprite_entry_tile_expander.sv =====
// Top level of the sprite entry tile expander: front decode, entry queue, back end.
// Depends on sete_pkg, sete_front, sete_queue and sete_back.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+-----------------------------------
//  entry    | in        | start high, busy low   | i_y_byte .. i_x_byte (5 x 8 bits)
//  command  | out       | o_strobe, one cycle    | o_tile_code .. o_last_tile
//  config   | in        | i_cfg_we               | i_cfg_wdata (variant select)
//
// An entry is taken every cycle while the queue has room; busy rises only when
// the queue is full. The back end emits one draw command per cycle, so an entry
// yields 1, 2 or 4 commands (set by its size bits); invisible entries yield none.
// With the back end idle, the first command reaches the outputs once the entry has
// passed the queue, entry hold and output registers; else it follows the entry ahead.
// Reset is synchronous, active low, and clears the queue, sequencer and variant
// register. The receiver cannot stall: every strobe is a delivered command.
module sprite_entry_tile_expander #(
    parameter int QUEUE_DEPTH = sete_pkg::SETE_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic [7:0]        i_y_byte,
    input  logic [7:0]        i_attr_byte,
    input  logic [7:0]        i_code_color_byte,
    input  logic [7:0]        i_code_low_byte,
    input  logic [7:0]        i_x_byte,
    output logic              o_strobe,
    output logic [13:0]       o_tile_code,
    output logic [2:0]        o_palette_color,
    output logic              o_flip_x,
    output logic              o_flip_y,
    output logic signed [9:0] o_screen_x,
    output logic signed [9:0] o_screen_y,
    output logic              o_last_tile
);
    import sete_pkg::*;

    logic   push;
    logic   pop;
    logic   q_empty;
    logic   q_full;
    t_entry front_entry;
    t_entry q_entry;

    assign busy = q_full;

    // Accept and decode
    sete_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_accept          (start & ~q_full),
        .i_y_byte          (i_y_byte),
        .i_attr_byte       (i_attr_byte),
        .i_code_color_byte (i_code_color_byte),
        .i_code_low_byte   (i_code_low_byte),
        .i_x_byte          (i_x_byte),
        .o_push            (push),
        .o_entry           (front_entry)
    );

    // Decoded entry queue
    sete_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (q_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Tile command generation
    sete_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_entry       (q_entry),
        .o_q_pop         (pop),
        .o_strobe        (o_strobe),
        .o_tile_code     (o_tile_code),
        .o_palette_color (o_palette_color),
        .o_flip_x        (o_flip_x),
        .o_flip_y        (o_flip_y),
        .o_screen_x      (o_screen_x),
        .o_screen_y      (o_screen_y),
        .o_last_tile     (o_last_tile)
    );

endmodule

// ===== hdl/sete_front.sv =====
// Front end: holds the variant register, decodes one sprite entry per cycle while i_accept is high.
// Depends on sete_pkg; feeds sete_queue.
module sete_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_accept,
    input  logic [7:0]      i_y_byte,
    input  logic [7:0]      i_attr_byte,
    input  logic [7:0]      i_code_color_byte,
    input  logic [7:0]      i_code_low_byte,
    input  logic [7:0]      i_x_byte,
    output logic            o_push,
    output sete_pkg::t_entry o_entry
);
    import sete_pkg::*;

    logic r_variant_two;
    logic n_variant_two;

    // Variant register
    always_comb begin
        n_variant_two = r_variant_two;
        if (i_cfg_we) begin
            n_variant_two = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant_two <= 1'b0;
        end else begin
            r_variant_two <= n_variant_two;
        end
    end

    // Invisible entries are dropped here
    assign o_push = i_accept & i_attr_byte[ATTR_VISIBLE];

    // Field decode
    always_comb begin
        if (r_variant_two) begin
            o_entry.color     = i_code_color_byte[7:5];
            o_entry.base_code = {i_code_color_byte[4:0], i_code_low_byte};
        end else begin
            o_entry.color     = i_code_color_byte[6:4];
            o_entry.base_code = {1'b0, i_code_color_byte[3:0], i_code_low_byte};
        end
        o_entry.flip_x = i_attr_byte[ATTR_XFLIP];
        o_entry.flip_y = i_attr_byte[ATTR_YFLIP];
        o_entry.size   = t_size'(i_attr_byte[ATTR_SIZE_HI:ATTR_SIZE_LO]);
        // 240 - byte, plus 256 from the high bit
        o_entry.pos_x  = SCREEN_ORIGIN - {2'b00, i_x_byte}
                         + {1'b0, i_attr_byte[ATTR_XHIGH], 8'h00};
        o_entry.pos_y  = SCREEN_ORIGIN - {2'b00, i_y_byte}
                         + {1'b0, i_attr_byte[ATTR_YHIGH], 8'h00};
    end

endmodule

// ===== hdl/sete_queue.sv =====
// Small FIFO of decoded entries between front and back.
// Depends on sete_pkg for the entry type.
module sete_queue #(
    parameter int DEPTH = sete_pkg::SETE_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sete_pkg::t_entry i_entry,
    input  logic             i_pop,
    output sete_pkg::t_entry o_entry,
    output logic             o_empty,
    output logic             o_full
);
    import sete_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry         r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr_ptr;
    logic [AW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;
    logic           do_push;
    logic           do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== hdl/sete_back.sv =====
// Back end: walks the tiles of one entry, one draw command per cycle.
// Depends on sete_pkg; pulls entries from sete_queue.
module sete_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  sete_pkg::t_entry  i_q_entry,
    output logic              o_q_pop,
    output logic              o_strobe,
    output logic [13:0]       o_tile_code,
    output logic [2:0]        o_palette_color,
    output logic              o_flip_x,
    output logic              o_flip_y,
    output logic signed [9:0] o_screen_x,
    output logic signed [9:0] o_screen_y,
    output logic              o_last_tile
);
    import sete_pkg::*;

    t_entry            r_ent;
    logic              r_active;
    logic [1:0]        r_k;
    logic              n_active;
    logic [1:0]        n_k;

    logic [1:0]        tile_ofs;
    logic [1:0]        last_k;
    logic              is_last;
    logic              load;

    logic              r_strobe;
    logic [13:0]       r_tile_code;
    logic [2:0]        r_color;
    logic              r_flip_x;
    logic              r_flip_y;
    logic signed [9:0] r_screen_x;
    logic signed [9:0] r_screen_y;
    logic              r_last;

    // Tile offset and last index for the current size
    always_comb begin
        unique case (r_ent.size)
            SIZE_1X1: begin
                tile_ofs = 2'd0;
                last_k   = 2'd0;
            end
            SIZE_1X2: begin
                tile_ofs = r_k;
                last_k   = 2'd1;
            end
            SIZE_2X1: begin
                tile_ofs = {r_k[0], 1'b0};
                last_k   = 2'd1;
            end
            default: begin
                tile_ofs = r_k;
                last_k   = 2'd3;
            end
        endcase
    end

    assign is_last = r_active & (r_k == last_k);
    assign load    = ~r_active | is_last;
    assign o_q_pop = load & ~i_q_empty;

    // Sequencer: load next entry or step the tile index
    always_comb begin
        n_active = r_active;
        n_k      = r_k;
        if (load) begin
            n_active = ~i_q_empty;
            n_k      = 2'd0;
        end else begin
            n_k      = r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_k      <= 2'd0;
            r_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            r_k      <= n_k;
            r_strobe <= r_active;
        end
    end

    // Entry hold and output registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ent <= i_q_entry;
        end
        r_tile_code <= {1'b0, r_ent.base_code} + {12'd0, tile_ofs};
        r_color     <= r_ent.color;
        r_flip_x    <= r_ent.flip_x;
        r_flip_y    <= r_ent.flip_y;
        r_screen_x  <= (r_ent.size[1] & ~tile_ofs[1]) ? r_ent.pos_x - TILE_STEP
                                                      : r_ent.pos_x;
        r_screen_y  <= (r_ent.size[0] & ~tile_ofs[0]) ? r_ent.pos_y - TILE_STEP
                                                      : r_ent.pos_y;
        r_last      <= is_last;
    end

    assign o_strobe        = r_strobe;
    assign o_tile_code     = r_tile_code;
    assign o_palette_color = r_color;
    assign o_flip_x        = r_flip_x;
    assign o_flip_y        = r_flip_y;
    assign o_screen_x      = r_screen_x;
    assign o_screen_y      = r_screen_y;
    assign o_last_tile     = r_last;

endmodule
